// ===== hw/rtl/tsut_pkg.sv =====
// ----------------------------------------------------------------------------
// Tolerant sorted unique table package
// Shared request and status codes, the float decoder and compare result type.
// ----------------------------------------------------------------------------
package tsut_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int CMP_LAT = 3;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_NAN       = 3'd4;

    typedef struct packed {
        logic        sgn;
        logic [10:0] e;
        logic [52:0] m;
        logic [62:0] mag;
        logic        zero;
        logic        inf;
        logic        nan;
    } fp_dec_t;

    typedef struct packed {
        logic valid;
        logic eq;
        logic lt;
    } cmp_res_t;

    // The exponent is unified so that subnormals share the exponent of the
    // lowest normal binade, and the hidden bit is made explicit.
    function automatic fp_dec_t fp_decode(logic [63:0] bits, logic fmt);
        fp_dec_t d;
        logic    ez;
        logic    eo;
        logic    fz;
        if (fmt)
        begin
            ez     = (bits[62:52] == 11'd0);
            eo     = (bits[62:52] == 11'h7FF);
            fz     = (bits[51:0] == 52'd0);
            d.sgn  = bits[63];
            d.e    = ez ? 11'd1 : bits[62:52];
            d.m    = {~ez, bits[51:0]};
            d.mag  = bits[62:0];
        end
        else
        begin
            ez     = (bits[30:23] == 8'd0);
            eo     = (bits[30:23] == 8'hFF);
            fz     = (bits[22:0] == 23'd0);
            d.sgn  = bits[31];
            d.e    = {3'd0, (ez ? 8'd1 : bits[30:23])};
            d.m    = {29'd0, ~ez, bits[22:0]};
            d.mag  = {32'd0, bits[30:0]};
        end
        d.zero = ez && fz;
        d.inf  = eo && fz;
        d.nan  = eo && !fz;
        return d;
    endfunction

endpackage

// ===== hw/rtl/tsut_cell.sv =====
// ----------------------------------------------------------------------------
// Table cell
// One table entry that takes its neighbor's entry whenever the ring turns.
// ----------------------------------------------------------------------------
module tsut_cell
(
    input  logic        clk,
    input  logic        shift,
    input  logic [63:0] din,
    output logic [63:0] dout
);

    logic [63:0] entry_reg;
    logic [63:0] entry_next;

    assign entry_next = shift ? din : entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign dout = entry_reg;

endmodule

// ===== hw/rtl/tsut_cmp.sv =====
// ----------------------------------------------------------------------------
// Tolerant compare pipeline
// Three stages that decide tolerant equality and strict order of an entry
// against the request value in the selected float format.
// ----------------------------------------------------------------------------
module tsut_cmp #(
    parameter int IW = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  logic                fmt,
    input  logic [63:0]         entry,
    input  logic [63:0]         value,
    input  logic [IW-1:0]       idx,
    output tsut_pkg::cmp_res_t  res,
    output logic [IW-1:0]       res_idx,
    output logic [63:0]         res_entry
);

    typedef struct packed {
        logic        exact;
        logic        lt;
        logic        same;
        logic        close;
        logic        special;
        logic        opp_near;
        logic [53:0] x;
        logic [54:0] s;
        logic [10:0] e0;
        logic        fmt;
    } s1_t;

    typedef struct packed {
        logic        exact;
        logic        lt;
        logic        same;
        logic        close;
        logic        special;
        logic        opp_near;
        logic        min_ok;
        logic [52:0] ms;
        logic [1:0]  shamt;
        logic [53:0] x;
        logic        fmt;
    } s2_t;

    logic [2:0]    vld_reg;
    logic [2:0]    vld_next;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [63:0]   ent1_reg, ent2_reg, ent3_reg;
    s1_t           s1_reg, s1_next;
    s2_t           s2_reg, s2_next;
    logic          eq_reg, eq_next;
    logic          lt_reg, lt_next;

    tsut_pkg::fp_dec_t da;
    tsut_pkg::fp_dec_t db;
    logic [10:0]   e0;
    logic [11:0]   ea_x;
    logic [11:0]   eb_x;
    logic [53:0]   a_al;
    logic [53:0]   b_al;
    logic [53:0]   msum;
    logic [5:0]    p1;

    always_comb
    begin
        da   = tsut_pkg::fp_decode(entry, fmt);
        db   = tsut_pkg::fp_decode(value, fmt);
        p1   = fmt ? 6'd53 : 6'd24;
        e0   = (da.e < db.e) ? da.e : db.e;
        ea_x = {1'b0, da.e};
        eb_x = {1'b0, db.e};
        a_al = (da.e != e0) ? {da.m, 1'b0} : {1'b0, da.m};
        b_al = (db.e != e0) ? {db.m, 1'b0} : {1'b0, db.m};
        msum = {1'b0, da.m} + {1'b0, db.m};

        s1_next.exact    = !(da.nan || db.nan) &&
                           (((da.mag == db.mag) && (da.sgn == db.sgn)) ||
                            (da.zero && db.zero));
        if (da.nan || db.nan || (da.zero && db.zero))
        begin
            s1_next.lt = 1'b0;
        end
        else if (da.sgn != db.sgn)
        begin
            s1_next.lt = da.sgn;
        end
        else
        begin
            s1_next.lt = da.sgn ? (da.mag > db.mag) : (da.mag < db.mag);
        end
        s1_next.same     = (da.sgn == db.sgn);
        s1_next.close    = (ea_x == eb_x) || (ea_x == eb_x + 12'd1) ||
                           (eb_x == ea_x + 12'd1);
        s1_next.special  = da.nan || db.nan || da.inf || db.inf;
        s1_next.opp_near = (da.e == 11'd1) && (db.e == 11'd1) &&
                           (msum < (54'd1 << (p1 - 6'd1)));
        s1_next.x        = (a_al >= b_al) ? (a_al - b_al) : (b_al - a_al);
        s1_next.s        = {1'b0, a_al} + {1'b0, b_al};
        s1_next.e0       = e0;
        s1_next.fmt      = fmt;
    end

    logic [5:0]  p2;
    logic [10:0] emaxf;
    logic [54:0] keep;
    logic        g;
    logic        st;
    logic [54:0] rsum;
    logic [11:0] es;
    logic        up;

    always_comb
    begin
        p2    = s1_reg.fmt ? 6'd53 : 6'd24;
        emaxf = s1_reg.fmt ? 11'h7FF : 11'h0FF;
        if (s1_reg.s[p2 + 6'd1])
        begin
            keep = s1_reg.s >> 2;
            g    = s1_reg.s[1];
            st   = s1_reg.s[0];
            es   = {1'b0, s1_reg.e0} + 12'd2;
        end
        else if (s1_reg.s[p2])
        begin
            keep = s1_reg.s >> 1;
            g    = s1_reg.s[0];
            st   = 1'b0;
            es   = {1'b0, s1_reg.e0} + 12'd1;
        end
        else
        begin
            keep = s1_reg.s;
            g    = 1'b0;
            st   = 1'b0;
            es   = {1'b0, s1_reg.e0};
        end
        up   = g && (st || keep[0]);
        rsum = keep + {54'd0, up};
        if (rsum[p2])
        begin
            rsum = rsum >> 1;
            es   = es + 12'd1;
        end
        if (es >= {1'b0, emaxf})
        begin
            rsum = 55'((55'd1 << p2) - 55'd1);
            es   = {1'b0, emaxf} - 12'd1;
        end

        s2_next.exact    = s1_reg.exact;
        s2_next.lt       = s1_reg.lt;
        s2_next.same     = s1_reg.same;
        s2_next.close    = s1_reg.close;
        s2_next.special  = s1_reg.special;
        s2_next.opp_near = s1_reg.opp_near;
        s2_next.min_ok   = ({1'b0, s1_reg.e0} < {6'd0, p2}) &&
                           ((s1_reg.x >> (p2 - s1_reg.e0[5:0])) == 54'd0);
        s2_next.ms       = rsum[52:0];
        s2_next.shamt    = 2'(es - {1'b0, s1_reg.e0});
        s2_next.x        = s1_reg.x;
        s2_next.fmt      = s1_reg.fmt;
    end

    logic [107:0] lhs;
    logic [107:0] rhs;
    logic         tol_lt;

    always_comb
    begin
        lhs     = {54'd0, s2_reg.x} << (s2_reg.fmt ? 7'd52 : 7'd23);
        rhs     = {55'd0, s2_reg.ms} << s2_reg.shamt;
        tol_lt  = lhs < rhs;
        eq_next = s2_reg.exact ||
                  (!s2_reg.special &&
                   (s2_reg.same ? (s2_reg.close && (s2_reg.min_ok || tol_lt))
                                : s2_reg.opp_near));
        lt_next = s2_reg.lt;
    end

    assign vld_next = {vld_reg[1:0], valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 3'd0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        eq_reg   <= eq_next;
        lt_reg   <= lt_next;
        idx1_reg <= idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ent1_reg <= entry;
        ent2_reg <= ent1_reg;
        ent3_reg <= ent2_reg;
    end

    assign res.valid = vld_reg[2];
    assign res.eq    = eq_reg;
    assign res.lt    = lt_reg;
    assign res_idx   = idx3_reg;
    assign res_entry = ent3_reg;

endmodule

// ===== hw/rtl/tolerant_sorted_unique_table_top.sv =====
// ----------------------------------------------------------------------------
// Tolerant sorted unique table
// Ascending table of distinct float values held in a rotating ring of cells.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we               cfg_wdata (float format)
//   in       in         in_valid/in_stall    req_type, value_bits, position
//   out      out        out_valid/out_stall  status, rank, value_out,
//                                            newly_added, entry_count
//
// A clear, a NaN and a read beyond the table go straight to the result.
// A read turns the ring once.
// A lookup, a matching insert or an insert into a full table turns the ring
// once to feed the compare pipeline, then lets it drain.
// An insert of a new value takes a second turn that shifts it in.
// A stalled result holds the block until it is taken. Reset empties the table
// and selects binary64. One item is in work at a time.
// ----------------------------------------------------------------------------
module tolerant_sorted_unique_table_top #(
    parameter int TABLE_DEPTH = tsut_pkg::TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] value_bits,
    input  logic [9:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [9:0]  rank,
    output logic [63:0] value_out,
    output logic        newly_added,
    output logic [10:0] entry_count
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic [CW-1:0] less_reg, less_next;
    logic [1:0]    drain_reg, drain_next;
    logic          fmt_reg, fmt_next;
    logic          out_valid_reg, out_valid_next;

    logic [1:0]    req_reg, req_next;
    logic [63:0]   val_reg, val_next;
    logic [9:0]    pos_reg, pos_next;
    logic [IW-1:0] midx_reg, midx_next;
    logic [63:0]   mval_reg, mval_next;
    logic [63:0]   carry_reg, carry_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [9:0]    res_rank_reg, res_rank_next;
    logic [63:0]   res_val_reg, res_val_next;
    logic          res_added_reg, res_added_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [9:0]    out_rank_reg, out_rank_next;
    logic [63:0]   out_value_reg, out_value_next;
    logic          out_added_reg, out_added_next;
    logic [CW-1:0] out_count_reg, out_count_next;

    logic [63:0]   cell_q [TABLE_DEPTH];
    logic [63:0]   head;
    logic [63:0]   feedback;
    logic          shift;
    logic          cmp_valid;

    tsut_pkg::cmp_res_t cres;
    logic [IW-1:0]      cres_idx;
    logic [63:0]        cres_entry;
    tsut_pkg::fp_dec_t  vin_dec;
    logic [63:0]        vin;
    logic               accept;
    logic               last_k;
    logic [IW+9:0]      midx_x;
    logic [IW+9:0]      k_x;
    logic [IW+9:0]      at_x;
    logic [CW+10:0]     cnt_x;

    assign head = cell_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_ring
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                tsut_cell u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din   (feedback),
                    .dout  (cell_q[gi])
                );
            end
            else
            begin : g_body
                tsut_cell u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din   (cell_q[gi+1]),
                    .dout  (cell_q[gi])
                );
            end
        end
    endgenerate

    assign cmp_valid = (state_reg == S_SCAN) &&
                       ({1'b0, k_reg} < (IW+1)'(count_reg));

    tsut_cmp #(.IW(IW)) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (cmp_valid),
        .fmt       (fmt_reg),
        .entry     (head),
        .value     (val_reg),
        .idx       (k_reg),
        .res       (cres),
        .res_idx   (cres_idx),
        .res_entry (cres_entry)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign vin      = fmt_reg ? value_bits : {32'd0, value_bits[31:0]};
    assign vin_dec  = tsut_pkg::fp_decode(vin, fmt_reg);
    assign last_k   = (k_reg == IW'(TABLE_DEPTH - 1));
    assign midx_x   = {10'd0, midx_reg};
    assign k_x      = {10'd0, k_reg};
    assign at_x     = {10'd0, less_reg[IW-1:0]};
    assign cnt_x    = {11'd0, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        less_next       = less_reg;
        drain_next      = drain_reg;
        fmt_next        = cfg_we ? cfg_wdata : fmt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        req_next        = req_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        midx_next       = midx_reg;
        mval_next       = mval_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_rank_next   = res_rank_reg;
        res_val_next    = res_val_reg;
        res_added_next  = res_added_reg;
        out_status_next = out_status_reg;
        out_rank_next   = out_rank_reg;
        out_value_next  = out_value_reg;
        out_added_next  = out_added_reg;
        out_count_next  = out_count_reg;
        shift           = 1'b0;
        feedback        = head;

        if (cres.valid)
        begin
            if (cres.eq && !found_reg)
            begin
                found_next = 1'b1;
                midx_next  = cres_idx;
                mval_next  = cres_entry;
            end
            if (cres.lt)
            begin
                less_next = less_reg + CW'(1);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req_type;
                    val_next        = vin;
                    pos_next        = position;
                    k_next          = '0;
                    found_next      = 1'b0;
                    less_next       = '0;
                    res_status_next = tsut_pkg::ST_OK;
                    res_rank_next   = 10'd0;
                    res_val_next    = 64'd0;
                    res_added_next  = 1'b0;
                    unique case (req_type)
                        tsut_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        tsut_pkg::REQ_READ:
                        begin
                            if ({{CW{1'b0}}, position} >= cnt_x[CW+9:0])
                            begin
                                res_status_next = tsut_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            if (vin_dec.nan)
                            begin
                                res_status_next = tsut_pkg::ST_NAN;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                shift  = 1'b1;
                k_next = k_reg + IW'(1);
                if (last_k)
                begin
                    drain_next = 2'd0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'(tsut_pkg::CMP_LAT - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                k_next = '0;
                if (found_reg)
                begin
                    res_rank_next = midx_x[9:0];
                    res_val_next  = mval_reg;
                    state_next    = S_DONE;
                end
                else if (req_reg == tsut_pkg::REQ_LOOKUP)
                begin
                    res_status_next = tsut_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    res_status_next = tsut_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                shift  = 1'b1;
                k_next = k_reg + IW'(1);
                if (k_reg == less_reg[IW-1:0])
                begin
                    feedback   = val_reg;
                    carry_next = head;
                end
                else if (k_x > at_x)
                begin
                    feedback   = carry_reg;
                    carry_next = head;
                end
                if (last_k)
                begin
                    count_next     = count_reg + CW'(1);
                    res_rank_next  = at_x[9:0];
                    res_val_next   = val_reg;
                    res_added_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_READ:
            begin
                shift  = 1'b1;
                k_next = k_reg + IW'(1);
                if (k_x == {{IW{1'b0}}, pos_reg})
                begin
                    res_val_next  = head;
                    res_rank_next = pos_reg;
                end
                if (last_k)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rank_next   = res_rank_reg;
                    out_value_next  = fmt_reg ? res_val_reg
                                              : {32'd0, res_val_reg[31:0]};
                    out_added_next  = res_added_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            less_reg      <= '0;
            drain_reg     <= 2'd0;
            fmt_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            less_reg      <= less_next;
            drain_reg     <= drain_next;
            fmt_reg       <= fmt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        midx_reg       <= midx_next;
        mval_reg       <= mval_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_rank_reg   <= res_rank_next;
        res_val_reg    <= res_val_next;
        res_added_reg  <= res_added_next;
        out_status_reg <= out_status_next;
        out_rank_reg   <= out_rank_next;
        out_value_reg  <= out_value_next;
        out_added_reg  <= out_added_next;
        out_count_reg  <= out_count_next;
    end

    logic [CW+10:0] ocnt_x;
    assign ocnt_x = {11'd0, out_count_reg};

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign rank        = out_rank_reg;
    assign value_out   = out_value_reg;
    assign newly_added = out_added_reg;
    assign entry_count = ocnt_x[10:0];

endmodule
